>>> hdl/afp_pkg.sv
// Shared types and command codes for the audio frame FIFO player.
// No dependencies; used by the top level and its checker.
package afp_pkg;

  localparam int unsigned CmdBits  = 3;
  localparam int unsigned FreeBits = 11;

  localparam logic [CmdBits-1:0] CMD_WRITE    = 3'd0;
  localparam logic [CmdBits-1:0] CMD_RENDER   = 3'd1;
  localparam logic [CmdBits-1:0] CMD_MARK_END = 3'd2;
  localparam logic [CmdBits-1:0] CMD_PLAY     = 3'd3;
  localparam logic [CmdBits-1:0] CMD_RESET    = 3'd4;

  localparam logic [1:0] CC_MONO  = 2'd1;
  localparam logic [1:0] CC_RESET = 2'd2;

  typedef struct packed {
    logic [CmdBits-1:0] cmd;
    logic [31:0]        sample_left;
    logic [31:0]        sample_right;
    logic               last_in_block;
    logic               play_on;
    logic [63:0]        start_frame;
  } afp_item_t;

  typedef struct packed {
    logic [31:0]         out_left;
    logic [31:0]         out_right;
    logic                accepted;
    logic                silent;
    logic [FreeBits-1:0] free_frames;
    logic [63:0]         frame_position;
    logic                finished;
    logic                playing;
  } afp_result_t;

endpackage

>>> hdl/audio_frame_fifo_player.sv
// Audio frame FIFO player: command channel, frame memory and result register.
// Depends on afp_pkg.
//
// Usage:
//   Commands arrive as afp_item_t on item_i and are taken on a clock edge with
//   start high and busy low. Each command gives exactly one result on
//   result_o, shown for one cycle with result_valid_o high; the receiver
//   cannot hold it off.
//   The result strobe is registered from busy, which is set at the accepting edge.
//   A new command is not taken while busy is high. The accepting edge reads the frame
//   memory at the read slot into a register (synchronous read); then the busy
//   cycle updates pointers, fill count and flags and writes a frame if needed.
//   busy is high during that update, so memory accesses never overlap.
//   The channel-count register is written over cfg_valid_i/cfg_data_i, which
//   is always ready; write it only while no command is in flight.
//   Reset clears pointers, fill count, flags and the frame counter and sets
//   the channel count to two. The frame memory is not cleared; the fill count
//   keeps unwritten entries out of every result.
module audio_frame_fifo_player
  import afp_pkg::*;
#(
  parameter int unsigned FRAME_CAPACITY = 1024,
  parameter int unsigned SAMPLE_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  afp_item_t   item_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  output logic        result_valid_o,
  output afp_result_t result_o
);

  localparam int unsigned AW = $clog2(FRAME_CAPACITY);
  localparam int unsigned FW = $clog2(FRAME_CAPACITY + 1);
  localparam int unsigned MW = 2 * SAMPLE_BITS;
  localparam logic [FW-1:0] CapFill = FW'(FRAME_CAPACITY);
  localparam logic [AW-1:0] LastSlot = AW'(FRAME_CAPACITY - 1);

  logic [MW-1:0] mem_q [FRAME_CAPACITY];
  logic [MW-1:0] rd_data_q;

  logic          busy_q;
  afp_item_t     item_q;
  logic [1:0]    cc_q;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [63:0]   played_q, played_d;
  logic          play_q, play_d;
  logic          ended_q, ended_d;
  logic          done_q, done_d;
  logic          under_q, under_d;
  logic          res_valid_q;
  afp_result_t   res_q, res_d;

  logic                   accept;
  logic                   mono;
  logic                   mem_we;
  logic [SAMPLE_BITS-1:0] wr_left, wr_right;
  logic                   under_now;

  assign accept      = start && !busy_q;
  assign busy        = busy_q;
  assign cfg_ready_o = 1'b1;
  assign mono        = (cc_q == CC_MONO);
  assign wr_left     = item_q.sample_left[SAMPLE_BITS-1:0];
  assign wr_right    = mono ? '0 : item_q.sample_right[SAMPLE_BITS-1:0];

  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    fill_d    = fill_q;
    played_d  = played_q;
    play_d    = play_q;
    ended_d   = ended_q;
    done_d    = done_q;
    under_d   = under_q;
    mem_we    = 1'b0;
    under_now = under_q;
    res_d     = '0;
    case (item_q.cmd)
      CMD_WRITE: begin
        if (fill_q != CapFill) begin
          mem_we         = 1'b1;
          wr_ptr_d       = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
          fill_d         = fill_q + 1'b1;
          res_d.accepted = 1'b1;
        end
      end
      CMD_RENDER: begin
        if (!play_q) begin
          res_d.silent = 1'b1;
        end else begin
          if (fill_q != '0) begin
            res_d.out_left  = 32'(rd_data_q[SAMPLE_BITS-1:0]);
            res_d.out_right = mono ? '0 : 32'(rd_data_q[MW-1:SAMPLE_BITS]);
            rd_ptr_d        = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
            fill_d          = fill_q - 1'b1;
            played_d        = played_q + 64'd1;
            res_d.accepted  = 1'b1;
          end else begin
            under_now = 1'b1;
          end
          under_d = under_now;
          // end of a block that ran dry after end of stream stops playback
          if (item_q.last_in_block && under_now && ended_q) begin
            play_d = 1'b0;
            done_d = 1'b1;
          end
        end
        if (item_q.last_in_block) begin
          under_d = 1'b0;
        end
      end
      CMD_MARK_END: begin
        ended_d = 1'b1;
      end
      CMD_PLAY: begin
        play_d = item_q.play_on;
        if (item_q.play_on) begin
          done_d = 1'b0;
        end
      end
      CMD_RESET: begin
        rd_ptr_d = '0;
        wr_ptr_d = '0;
        fill_d   = '0;
        played_d = item_q.start_frame;
        ended_d  = 1'b0;
        done_d   = 1'b0;
        under_d  = 1'b0;
      end
      default: begin
      end
    endcase
    res_d.free_frames    = FreeBits'(CapFill - fill_d);
    res_d.frame_position = played_d;
    res_d.finished       = done_d;
    res_d.playing        = play_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && mem_we) begin
      mem_q[wr_ptr_q] <= {wr_right, wr_left};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (busy_q) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
      cc_q        <= CC_RESET;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      played_q    <= '0;
      play_q      <= 1'b0;
      ended_q     <= 1'b0;
      done_q      <= 1'b0;
      under_q     <= 1'b0;
    end else begin
      res_valid_q <= busy_q;
      if (cfg_valid_i) begin
        cc_q <= cfg_data_i;
      end
      if (busy_q) begin
        busy_q   <= 1'b0;
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
        fill_q   <= fill_d;
        played_q <= played_d;
        play_q   <= play_d;
        ended_q  <= ended_d;
        done_q   <= done_d;
        under_q  <= under_d;
      end else if (accept) begin
        busy_q <= 1'b1;
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

>>> hdl/afp_checker.sv
// Port-level checker for audio_frame_fifo_player, attached by bind.
// Depends on afp_pkg.
module afp_checker
  import afp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input afp_result_t result_o
);

  // every accepted command yields its result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 result_valid_o)
    else $error("result strobe missing after accepted command");

  // the command channel is held off while a command executes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.silent) |->
      (!result_o.accepted && result_o.out_left == '0 && result_o.out_right == '0))
    else $error("silent render carried data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.finished) |-> !result_o.playing)
    else $error("finished while still playing");

endmodule

bind audio_frame_fifo_player afp_checker u_afp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

>>> test/tb_audio_frame_fifo_player.sv
// Self-checking bench for audio_frame_fifo_player: directed command table, a fill sweep
// to full and past the write slot wrap, then random command sessions under three settings.
// Depends on afp_pkg and the RTL top level; a behavioral FIFO player predicts every result.
module tb_audio_frame_fifo_player;
  timeunit 1ns;
  timeprecision 1ps;
  import afp_pkg::*;

  localparam int unsigned Frames   = 1024;
  localparam int unsigned SlotBits = $clog2(Frames);
  localparam int unsigned MaxLoud  = 30;

  localparam logic [CmdBits-1:0] CMD_UNUSED_FIRST = CMD_RESET + 3'd1;
  localparam logic [CmdBits-1:0] CMD_UNUSED_LAST  = '1;

  // channel_count values other than mono all behave as stereo
  localparam logic [1:0] CC_ALIAS_LO = 2'd0;
  localparam logic [1:0] CC_ALIAS_HI = 2'd3;

  typedef struct {
    afp_item_t   it;
    bit          typed;
    afp_result_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  afp_item_t   item_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i;
  logic        result_valid_o;
  afp_result_t result_o;

  audio_frame_fifo_player dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // player state as the bench sees it
  logic [63:0]         frame_mem [Frames];
  logic [FreeBits-1:0] rd_ptr = '0;
  logic [FreeBits-1:0] wr_ptr = '0;
  logic [63:0]         played = '0;
  logic                play_en = 1'b0;
  logic                eos = 1'b0;
  logic                done_fl = 1'b0;
  logic                blk_under = 1'b0;
  logic [1:0]          chan_cnt = CC_RESET;

  afp_result_t pending_results [$];
  stim_row_t   directed_rows [$];
  int          idle_pct = 0;
  int          mismatches = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_drops = 0;
  int          n_underruns = 0;
  int          n_stops = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_audio_frame_fifo_player failed");
    $finish;
  end

  function automatic afp_result_t predict_result(input afp_item_t it);
    afp_result_t         r;
    logic [FreeBits-1:0] fill;
    logic                mono;
    r    = '0;
    mono = (chan_cnt == CC_MONO);
    fill = wr_ptr - rd_ptr;
    case (it.cmd)
      CMD_WRITE: begin
        if (fill < FreeBits'(Frames)) begin
          frame_mem[wr_ptr[SlotBits-1:0]] = {mono ? 32'h0 : it.sample_right, it.sample_left};
          wr_ptr     = wr_ptr + 1'b1;
          r.accepted = 1'b1;
        end else begin
          n_drops++;
        end
      end
      CMD_RENDER: begin
        if (!play_en) begin
          r.silent = 1'b1;
        end else begin
          if (fill != '0) begin
            r.out_left  = frame_mem[rd_ptr[SlotBits-1:0]][31:0];
            r.out_right = mono ? 32'h0 : frame_mem[rd_ptr[SlotBits-1:0]][63:32];
            rd_ptr      = rd_ptr + 1'b1;
            played      = played + 64'd1;
            r.accepted  = 1'b1;
          end else begin
            blk_under = 1'b1;
            n_underruns++;
          end
          if (it.last_in_block && blk_under && eos) begin
            play_en = 1'b0;
            done_fl = 1'b1;
            n_stops++;
          end
        end
        // each render block starts clean, even one rendered while stopped
        if (it.last_in_block) blk_under = 1'b0;
      end
      CMD_MARK_END: eos = 1'b1;
      CMD_PLAY: begin
        play_en = it.play_on;
        if (it.play_on) done_fl = 1'b0;
      end
      CMD_RESET: begin
        rd_ptr    = '0;
        wr_ptr    = '0;
        played    = it.start_frame;
        eos       = 1'b0;
        done_fl   = 1'b0;
        blk_under = 1'b0;
      end
      default: ;
    endcase
    r.free_frames    = FreeBits'(Frames) - (wr_ptr - rd_ptr);
    r.frame_position = played;
    r.finished       = done_fl;
    r.playing        = play_en;
    return r;
  endfunction

  function automatic afp_item_t mk_cmd(input logic [CmdBits-1:0] cmd, input logic [31:0] left,
                                       input logic [31:0] right, input logic last,
                                       input logic on, input logic [63:0] load_val);
    afp_item_t it;
    it.cmd           = cmd;
    it.sample_left   = left;
    it.sample_right  = right;
    it.last_in_block = last;
    it.play_on       = on;
    it.start_frame   = load_val;
    return it;
  endfunction

  function automatic afp_item_t rand_item();
    afp_item_t it;
    it.cmd           = CmdBits'($urandom_range(7));
    it.sample_left   = $urandom;
    it.sample_right  = $urandom;
    it.last_in_block = 1'($urandom);
    it.play_on       = 1'($urandom);
    it.start_frame   = {$urandom, $urandom};
    return it;
  endfunction

  function automatic afp_result_t status(input logic [31:0] left, input logic [31:0] right,
                                         input logic acc, input logic sil, input int free,
                                         input logic [63:0] pos, input logic fin,
                                         input logic on);
    afp_result_t r;
    r.out_left       = left;
    r.out_right      = right;
    r.accepted       = acc;
    r.silent         = sil;
    r.free_frames    = FreeBits'(free);
    r.frame_position = pos;
    r.finished       = fin;
    r.playing        = on;
    return r;
  endfunction

  task automatic add_row(input afp_item_t it, input bit typed, input afp_result_t want);
    stim_row_t row;
    row.it    = it;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < MaxLoud)
      $display("%0t: mismatch on %s, got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // one command beat; returns at the accepting edge with start still high
  task automatic send_cmd(input afp_item_t it, input bit typed, input afp_result_t typed_want);
    afp_result_t want;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    want = predict_result(it);
    pending_results.push_back(typed ? typed_want : want);
    n_sent++;
  endtask

  task automatic set_channels(input logic [1:0] count);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    chan_cnt = count;
  endtask

  task automatic random_session(input int wanted);
    afp_item_t it;
    int        sent;
    int        len;
    int        pick;
    sent = 0;
    while (sent < wanted) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        len = $urandom_range(10, 1);
        repeat (len) begin
          it     = rand_item();
          it.cmd = CMD_WRITE;
          send_cmd(it, 1'b0, '0);
        end
        sent += len;
      end else if (pick < 75) begin
        len = $urandom_range(12, 1);
        for (int k = 0; k < len; k++) begin
          it               = rand_item();
          it.cmd           = CMD_RENDER;
          it.last_in_block = (k == len - 1);
          send_cmd(it, 1'b0, '0);
        end
        sent += len;
      end else if (pick < 86) begin
        it         = rand_item();
        it.cmd     = CMD_PLAY;
        it.play_on = (pick < 82);
        send_cmd(it, 1'b0, '0);
        sent++;
      end else if (pick < 90) begin
        it     = rand_item();
        it.cmd = CMD_MARK_END;
        send_cmd(it, 1'b0, '0);
        sent++;
      end else if (pick < 94) begin
        it     = rand_item();
        it.cmd = CMD_RESET;
        case ($urandom_range(2))
          0:       it.start_frame = '1 - 64'($urandom_range(3));
          1:       it.start_frame = '0;
          default: ;
        endcase
        send_cmd(it, 1'b0, '0);
        sent++;
      end else begin
        // noise: any code, any field, including broken render blocks
        it = rand_item();
        send_cmd(it, 1'b0, '0);
        if (it.cmd <= CMD_RESET) sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    afp_result_t got;
    afp_result_t want;
    if (rst_ni && result_valid_o) begin
      got = result_o;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", got.frame_position, '0);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.out_left !== want.out_left)
          flag_mismatch("out_left", 64'(got.out_left), 64'(want.out_left));
        if (got.out_right !== want.out_right)
          flag_mismatch("out_right", 64'(got.out_right), 64'(want.out_right));
        if (got.accepted !== want.accepted)
          flag_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
        if (got.silent !== want.silent)
          flag_mismatch("silent", 64'(got.silent), 64'(want.silent));
        if (got.free_frames !== want.free_frames)
          flag_mismatch("free_frames", 64'(got.free_frames), 64'(want.free_frames));
        if (got.frame_position !== want.frame_position)
          flag_mismatch("frame_position", got.frame_position, want.frame_position);
        if (got.finished !== want.finished)
          flag_mismatch("finished", 64'(got.finished), 64'(want.finished));
        if (got.playing !== want.playing)
          flag_mismatch("playing", 64'(got.playing), 64'(want.playing));
      end
    end
  end

  initial begin
    afp_item_t it;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = CC_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // render while stopped, full-scale and zero frames, unused codes
    add_row(mk_cmd(CMD_RENDER, '0, '0, 1'b1, 1'b0, '0), 1'b1,
            status('0, '0, 1'b0, 1'b1, 1024, '0, 1'b0, 1'b0));
    add_row(mk_cmd(CMD_WRITE, '1, '1, 1'b0, 1'b0, '0), 1'b1,
            status('0, '0, 1'b1, 1'b0, 1023, '0, 1'b0, 1'b0));
    add_row(mk_cmd(CMD_WRITE, '0, '0, 1'b1, 1'b1, '1), 1'b0, '0);
    add_row(mk_cmd(CMD_UNUSED_FIRST, '1, '1, 1'b1, 1'b1, '1), 1'b1,
            status('0, '0, 1'b0, 1'b0, 1022, '0, 1'b0, 1'b0));
    add_row(mk_cmd(CMD_UNUSED_LAST, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_PLAY, '0, '0, 1'b0, 1'b1, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_RENDER, '0, '0, 1'b0, 1'b0, '0), 1'b1,
            status('1, '1, 1'b1, 1'b0, 1023, 64'd1, 1'b0, 1'b1));
    add_row(mk_cmd(CMD_RENDER, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
    // underrun without end of stream keeps playing
    add_row(mk_cmd(CMD_RENDER, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_RENDER, '0, '0, 1'b1, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_MARK_END, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_RENDER, '0, '0, 1'b1, 1'b0, '0), 1'b1,
            status('0, '0, 1'b0, 1'b0, 1024, 64'd2, 1'b1, 1'b0));
    // pausing leaves finished set, playing clears it
    add_row(mk_cmd(CMD_PLAY, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_RENDER, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_PLAY, '0, '0, 1'b0, 1'b1, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_RESET, '0, '0, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE), 1'b1,
            status('0, '0, 1'b0, 1'b0, 1024, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b1));
    // frame counter wraps
    add_row(mk_cmd(CMD_WRITE, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_WRITE, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_RENDER, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_RENDER, '0, '0, 1'b1, 1'b0, '0), 1'b0, '0);
    // stopped render with last clears the block underrun
    add_row(mk_cmd(CMD_RENDER, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_PLAY, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_RENDER, '0, '0, 1'b1, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_PLAY, '0, '0, 1'b0, 1'b1, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_MARK_END, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_WRITE, 32'h8000_0001, 32'h7FFF_FFFE, 1'b0, 1'b0, '0), 1'b0, '0);
    add_row(mk_cmd(CMD_RENDER, '0, '0, 1'b1, 1'b0, '0), 1'b0, '0);

    idle_pct = 31;
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

    // fill to full with drops, drain a little, refill past the write slot wrap
    set_channels(CC_RESET);
    it     = rand_item();
    it.cmd = CMD_RESET;
    send_cmd(it, 1'b0, '0);
    repeat (Frames + 6) begin
      it     = rand_item();
      it.cmd = CMD_WRITE;
      send_cmd(it, 1'b0, '0);
    end
    it         = rand_item();
    it.cmd     = CMD_PLAY;
    it.play_on = 1'b1;
    send_cmd(it, 1'b0, '0);
    for (int k = 0; k < 24; k++) begin
      it               = rand_item();
      it.cmd           = CMD_RENDER;
      it.last_in_block = (k % 8 == 7);
      send_cmd(it, 1'b0, '0);
    end
    repeat (30) begin
      it     = rand_item();
      it.cmd = CMD_WRITE;
      send_cmd(it, 1'b0, '0);
    end
    it     = rand_item();
    it.cmd = CMD_RESET;
    send_cmd(it, 1'b0, '0);

    set_channels(CC_ALIAS_HI);
    idle_pct = 31;
    random_session(60);
    set_channels(CC_MONO);
    idle_pct = 50;
    random_session(60);
    set_channels(CC_ALIAS_LO);
    idle_pct = 0;
    random_session(66);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    $display("covered %0d commands over four channel settings, %0d results checked", n_sent,
             n_checked);
    $display("seen: %0d writes dropped on full, %0d render underruns, %0d end-of-stream stops",
             n_drops, n_underruns, n_stops);
    if (mismatches == 0) begin
      $display("tb_audio_frame_fifo_player passed");
    end else begin
      $display("tb_audio_frame_fifo_player failed");
    end
    $finish;
  end

endmodule

>>> audio_frame_fifo_player.f
hdl/afp_pkg.sv
hdl/audio_frame_fifo_player.sv
hdl/afp_checker.sv
test/tb_audio_frame_fifo_player.sv
